// ===== sv/lc2k_pkg.sv =====
package lc2k_pkg;

	localparam int NUM_REGS = 8;
	localparam int REG_W    = $clog2(NUM_REGS);

	// instruction field positions
	localparam int OPC_LSB  = 22;
	localparam int REGA_LSB = 19;
	localparam int REGB_LSB = 16;
	localparam int INS_W    = 25;

	typedef logic [31:0] word_t;
	typedef logic [REG_W-1:0] reg_idx_t;

	typedef enum logic [1:0] {
		OP_WRITE_MEM = 2'd0,
		OP_EXECUTE   = 2'd1,
		OP_READ_MEM  = 2'd2,
		OP_READ_REG  = 2'd3
	} operation_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_HALT    = 2'd1,
		STAT_STOPPED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OPC_ADD  = 3'd0,
		OPC_NOR  = 3'd1,
		OPC_LW   = 3'd2,
		OPC_SW   = 3'd3,
		OPC_BEQ  = 3'd4,
		OPC_JALR = 3'd5,
		OPC_HALT = 3'd6,
		OPC_NOOP = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic     rd_en;
		reg_idx_t a_addr;
		reg_idx_t b_addr;
		logic     wr_en;
		reg_idx_t wr_addr;
		word_t    wr_data;
	} rf_req_t;

	function automatic word_t sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

// ===== sv/lc2k_word_mem.sv =====
module lc2k_word_mem
	import lc2k_pkg::*;
#(
	parameter int MEM_WORDS = 4096
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(MEM_WORDS)-1:0] waddr,
	input  word_t                        wdata,
	input  logic                         re,
	input  logic [$clog2(MEM_WORDS)-1:0] raddr,
	output word_t                        rdata
);

	word_t mem [MEM_WORDS];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next enabled read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/lc2k_reg_file.sv =====
module lc2k_reg_file
	import lc2k_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  rf_req_t req,
	output word_t   a_data,
	output word_t   b_data
);

	word_t               mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	word_t               a_mem_q;
	word_t               b_mem_q;
	logic                a_valid_q;
	logic                b_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// an entry never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			a_mem_q <= mem[req.a_addr];
			b_mem_q <= mem[req.b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
		end else if (req.rd_en) begin
			a_valid_q <= valid_q[req.a_addr];
			b_valid_q <= valid_q[req.b_addr];
		end
	end

	assign a_data = a_valid_q ? a_mem_q : '0;
	assign b_data = b_valid_q ? b_mem_q : '0;

endmodule

// ===== sv/lc2k_instruction_executor_top.sv =====
// Channel  | Signals                                     | Handshake
// ---------+---------------------------------------------+------------------------------
// command  | operation, address, store_data              | taken when start & !busy
// result   | read_data, program_counter, status,         | one-cycle done strobe,
//          | executed_count                              | no back-pressure
// config   | cfg_data                                    | written when cfg_write_enable
//
// Memory writes, memory reads and register reads pass the accept and memory read steps.
// Execute goes through fetch read, register read and execute, with an extra data read for lw;
// a stopped machine answers after the fetch read. Word memory has a single read port, so
// the lw data read takes its own step. The done strobe is in the cycle after the last step;
// a new word can be taken in it. After reset busy stays high while word memory is zeroed.
// MEM_WORDS must be a power of two.
module lc2k_instruction_executor_top
	import lc2k_pkg::*;
#(
	parameter int MEM_WORDS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [11:0] address,
	input  logic [31:0] store_data,
	input  logic        cfg_write_enable,
	input  logic [12:0] cfg_data,
	output logic        done,
	output logic [31:0] read_data,
	output logic [11:0] program_counter,
	output logic [1:0]  status,
	output logic [31:0] executed_count
);

	localparam int ADDR_W = $clog2(MEM_WORDS);

	typedef logic [ADDR_W-1:0] maddr_t;

	state_t     state_q, state_nxt;
	maddr_t     clr_q;
	operation_t op_q;
	logic [INS_W-1:0] ins_q;
	maddr_t     pc_q;
	logic       halted_q;
	word_t      count_q;
	logic [12:0] plen_q;
	logic       done_q;
	word_t      rdata_q;
	status_t    status_q;

	logic       accept;
	logic       mem_we, mem_re;
	maddr_t     mem_waddr, mem_raddr;
	word_t      mem_wdata, mem_rdata;
	rf_req_t    rf_req;
	word_t      rf_a, rf_b;

	logic       res_load;
	word_t      res_data;
	status_t    res_status;

	opcode_t    opcode;
	reg_idx_t   ra, rb, rd;
	word_t      off, pc_ext, pc_plus1, eff_addr, br_target, addr_ext;
	maddr_t     addr_wrap, pc_exec_nxt;
	logic       stop;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign addr_ext  = 32'(address);
	assign addr_wrap = addr_ext[ADDR_W-1:0];

	assign opcode    = opcode_t'(ins_q[OPC_LSB +: 3]);
	assign ra        = ins_q[REGA_LSB +: REG_W];
	assign rb        = ins_q[REGB_LSB +: REG_W];
	assign rd        = ins_q[REG_W-1:0];
	assign off       = sext16(ins_q[15:0]);
	assign pc_ext    = 32'(pc_q);
	assign pc_plus1  = pc_ext + 32'd1;
	assign eff_addr  = rf_a + off;
	assign br_target = pc_plus1 + off;
	assign stop      = halted_q || (pc_ext >= 32'(plen_q));

	always_comb begin
		unique case (opcode)
			OPC_BEQ:  pc_exec_nxt = (rf_a == rf_b) ? br_target[ADDR_W-1:0]
			                                       : pc_plus1[ADDR_W-1:0];
			// link is written first, so ra == rb lands on pc + 1
			OPC_JALR: pc_exec_nxt = (ra == rb) ? pc_plus1[ADDR_W-1:0] : rf_a[ADDR_W-1:0];
			default:  pc_exec_nxt = pc_plus1[ADDR_W-1:0];
		endcase
	end

	lc2k_word_mem #(
		.MEM_WORDS (MEM_WORDS)
	) u_word_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lc2k_reg_file u_reg_file (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rf_req),
		.a_data (rf_a),
		.b_data (rf_b)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == maddr_t'(MEM_WORDS - 1)) state_nxt = ST_IDLE;
			ST_IDLE:  if (accept) state_nxt = ST_FETCH;
			ST_FETCH: state_nxt = (op_q == OP_EXECUTE && !stop) ? ST_EXEC : ST_IDLE;
			ST_EXEC:  state_nxt = (opcode == OPC_LW) ? ST_LOAD : ST_IDLE;
			ST_LOAD:  state_nxt = ST_IDLE;
			default:  state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		rf_req     = '0;
		res_load   = 1'b0;
		res_data   = '0;
		res_status = STAT_DONE;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (operation_t'(operation))
						OP_WRITE_MEM: begin
							mem_we    = 1'b1;
							mem_waddr = addr_wrap;
							mem_wdata = store_data;
						end
						OP_EXECUTE: begin
							mem_re    = 1'b1;
							mem_raddr = pc_q;
						end
						OP_READ_MEM: begin
							mem_re    = 1'b1;
							mem_raddr = addr_wrap;
						end
						OP_READ_REG: begin
							rf_req.rd_en  = 1'b1;
							rf_req.a_addr = address[REG_W-1:0];
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				// instruction word is on the memory output now
				if (op_q == OP_EXECUTE && !stop) begin
					rf_req.rd_en  = 1'b1;
					rf_req.a_addr = mem_rdata[REGA_LSB +: REG_W];
					rf_req.b_addr = mem_rdata[REGB_LSB +: REG_W];
				end else begin
					res_load = 1'b1;
					if (op_q == OP_READ_MEM) begin
						res_data = mem_rdata;
					end else if (op_q == OP_READ_REG) begin
						res_data = rf_a;
					end
					if (op_q == OP_EXECUTE) begin
						res_status = STAT_STOPPED;
					end
				end
			end
			ST_EXEC: begin
				res_load = (opcode != OPC_LW);
				unique case (opcode)
					OPC_ADD: begin
						rf_req.wr_en   = 1'b1;
						rf_req.wr_addr = rd;
						rf_req.wr_data = rf_a + rf_b;
					end
					OPC_NOR: begin
						rf_req.wr_en   = 1'b1;
						rf_req.wr_addr = rd;
						rf_req.wr_data = ~(rf_a | rf_b);
					end
					OPC_LW: begin
						mem_re    = 1'b1;
						mem_raddr = eff_addr[ADDR_W-1:0];
					end
					OPC_SW: begin
						mem_we    = 1'b1;
						mem_waddr = eff_addr[ADDR_W-1:0];
						mem_wdata = rf_b;
					end
					OPC_JALR: begin
						rf_req.wr_en   = 1'b1;
						rf_req.wr_addr = rb;
						rf_req.wr_data = pc_plus1;
					end
					OPC_HALT: res_status = STAT_HALT;
					default: ;
				endcase
			end
			ST_LOAD: begin
				rf_req.wr_en   = 1'b1;
				rf_req.wr_addr = rb;
				rf_req.wr_data = mem_rdata;
				res_load       = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			op_q     <= OP_WRITE_MEM;
			pc_q     <= '0;
			halted_q <= 1'b0;
			count_q  <= '0;
			plen_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= res_load;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + maddr_t'(1);
			end
			if (accept) begin
				op_q <= operation_t'(operation);
			end
			if (cfg_write_enable) begin
				plen_q <= cfg_data;
			end
			if (state_q == ST_FETCH && op_q == OP_EXECUTE && !stop) begin
				if (count_q != '1) begin
					count_q <= count_q + 32'd1;
				end
			end
			if (state_q == ST_EXEC) begin
				pc_q <= pc_exec_nxt;
				if (opcode == OPC_HALT) begin
					halted_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			ins_q <= mem_rdata[INS_W-1:0];
		end
		if (res_load) begin
			rdata_q  <= res_data;
			status_q <= res_status;
		end
	end

	assign done            = done_q;
	assign read_data       = rdata_q;
	assign program_counter = pc_ext[11:0];
	assign status          = status_q;
	assign executed_count  = count_q;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	import lc2k_pkg::*;

	localparam int MEM_WORDS = 4096;

	typedef struct packed {
		word_t       read_data;
		logic [11:0] pc;
		status_t     status;
		logic [31:0] count;
	} exec_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	operation_t  operation;
	logic [11:0] address;
	logic [31:0] store_data;
	logic        cfg_write_enable;
	logic [12:0] cfg_data;
	logic        done;
	logic [31:0] read_data;
	logic [11:0] program_counter;
	logic [1:0]  status;
	logic [31:0] executed_count;

	// machine image kept alongside the block
	word_t       mem_image [MEM_WORDS];
	word_t       reg_image [NUM_REGS];
	logic [11:0] pc_image;
	logic        halted_image;
	logic [31:0] count_image;
	logic [12:0] length_image;

	exec_result_t pending_results [$];
	int           failures;
	logic         idle_on;

	lc2k_instruction_executor_top #(.MEM_WORDS(MEM_WORDS)) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.address          (address),
		.store_data       (store_data),
		.cfg_write_enable (cfg_write_enable),
		.cfg_data         (cfg_data),
		.done             (done),
		.read_data        (read_data),
		.program_counter  (program_counter),
		.status           (status),
		.executed_count   (executed_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic word_t encode(input opcode_t opc, input reg_idx_t ra, input reg_idx_t rb,
		input logic [15:0] low);
		return {7'd0, opc, ra, rb, low};
	endfunction

	function automatic status_t execute_at_pc();
		word_t       ins;
		word_t       offset;
		word_t       target;
		logic [11:0] pc_old;
		reg_idx_t    ra;
		reg_idx_t    rb;
		reg_idx_t    rd;
		if (halted_image || {1'b0, pc_image} >= length_image)
			return STAT_STOPPED;
		pc_old = pc_image;
		ins    = mem_image[pc_old];
		ra     = ins[REGA_LSB +: 3];
		rb     = ins[REGB_LSB +: 3];
		rd     = ins[2:0];
		offset = {{16{ins[15]}}, ins[15:0]};
		if (count_image != 32'hFFFF_FFFF)
			count_image = count_image + 32'd1;
		pc_image = pc_old + 12'd1;
		case (ins[OPC_LSB +: 3])
			OPC_ADD: reg_image[rd] = reg_image[ra] + reg_image[rb];
			OPC_NOR: reg_image[rd] = ~(reg_image[ra] | reg_image[rb]);
			OPC_LW: begin
				target = reg_image[ra] + offset;
				reg_image[rb] = mem_image[target[11:0]];
			end
			OPC_SW: begin
				target = reg_image[ra] + offset;
				mem_image[target[11:0]] = reg_image[rb];
			end
			OPC_BEQ: begin
				if (reg_image[ra] == reg_image[rb]) begin
					target = {20'd0, pc_old} + offset + 32'd1;
					pc_image = target[11:0];
				end
			end
			OPC_JALR: begin
				// link goes in first: same register means jump to pc+1
				reg_image[rb] = {20'd0, pc_old} + 32'd1;
				target = reg_image[ra];
				pc_image = target[11:0];
			end
			OPC_HALT: begin
				halted_image = 1'b1;
				return STAT_HALT;
			end
			default: ;
		endcase
		return STAT_DONE;
	endfunction

	function automatic exec_result_t step_machine(input operation_t op, input logic [11:0] addr,
		input word_t data);
		exec_result_t r;
		r.read_data = '0;
		r.status    = STAT_DONE;
		case (op)
			OP_WRITE_MEM: mem_image[addr] = data;
			OP_EXECUTE:   r.status = execute_at_pc();
			OP_READ_MEM:  r.read_data = mem_image[addr];
			default:      r.read_data = reg_image[addr[2:0]];
		endcase
		r.pc    = pc_image;
		r.count = count_image;
		return r;
	endfunction

	task automatic send_word(input operation_t op, input logic [11:0] addr, input word_t data);
		if (idle_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 15)) @(negedge clk);
		operation  = op;
		address    = addr;
		store_data = data;
		start      = 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(step_machine(op, addr, data));
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic write_program_length(input logic [12:0] value);
		while (pending_results.size() != 0 || busy) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_data         = value;
		cfg_write_enable = 1'b1;
		@(negedge clk);
		cfg_write_enable = 1'b0;
		length_image     = value;
	endtask

	function automatic word_t random_instruction();
		word_t       ins;
		logic [2:0]  opc;
		int          small_off;
		ins = $urandom();
		opc = 3'($urandom_range(0, 7));
		if (opc == OPC_HALT)
			opc = OPC_NOOP;
		ins[OPC_LSB +: 3] = opc;
		// keep most branches and loads close by
		if ($urandom_range(0, 3) != 0) begin
			small_off = $urandom_range(0, 16) - 8;
			ins[15:0] = small_off[15:0];
		end
		return ins;
	endfunction

	task automatic test_reset_state();
		write_program_length(13'd0);
		send_word(OP_READ_REG, 12'hFF8, 32'hFFFF_FFFF);
		send_word(OP_READ_MEM, 12'hFFF, 32'h0);
		send_word(OP_EXECUTE, 12'h0, 32'h0);  // zero length: stopped
	endtask

	task automatic test_directed_program();
		write_program_length(13'd4096);
		send_word(OP_WRITE_MEM, 12'd20, 32'h7FFF_FFFF);
		send_word(OP_WRITE_MEM, 12'd21, 32'h8000_0000);
		send_word(OP_WRITE_MEM, 12'd0, encode(OPC_LW, 3'd0, 3'd1, 16'd20));
		send_word(OP_WRITE_MEM, 12'd1, encode(OPC_LW, 3'd0, 3'd2, 16'd21));
		send_word(OP_WRITE_MEM, 12'd2, encode(OPC_ADD, 3'd1, 3'd2, 16'd3));
		send_word(OP_WRITE_MEM, 12'd3, encode(OPC_NOR, 3'd1, 3'd0, 16'd4));
		// negative offset from r0 wraps to the top word
		send_word(OP_WRITE_MEM, 12'd4, encode(OPC_SW, 3'd0, 3'd3, 16'hFFFF));
		send_word(OP_WRITE_MEM, 12'd5, encode(OPC_BEQ, 3'd2, 3'd4, 16'd1));
		send_word(OP_WRITE_MEM, 12'd7, encode(OPC_BEQ, 3'd1, 3'd2, 16'hFFFB));
		send_word(OP_WRITE_MEM, 12'd8, encode(OPC_JALR, 3'd6, 3'd6, 16'd0));
		send_word(OP_WRITE_MEM, 12'd9, encode(OPC_JALR, 3'd3, 3'd7, 16'd0));
		// runs through 4095 (all-ones word, a noop) and wraps pc to 0
		repeat (10) send_word(OP_EXECUTE, 12'h0, 32'h0);
		send_word(OP_READ_REG, 12'hFFF, 32'h0);
		send_word(OP_READ_REG, 12'd6, 32'h0);
		send_word(OP_READ_MEM, 12'hFFF, 32'h0);
	endtask

	task automatic test_random_mix(input int count);
		int          pick;
		logic [11:0] rand_addr;
		word_t       rand_data;
		for (int i = 0; i < count; i++) begin
			pick      = $urandom_range(0, 99);
			rand_data = $urandom();
			rand_addr = 12'($urandom());
			if (pick < 40)
				send_word(OP_EXECUTE, rand_addr, rand_data);
			else if (pick < 70)
				send_word(OP_WRITE_MEM, pc_image + 12'($urandom_range(0, 3)),
					random_instruction());
			else if (pick < 80)
				send_word(OP_WRITE_MEM, rand_addr, rand_data);
			else if (pick < 90)
				send_word(OP_READ_MEM, rand_addr, rand_data);
			else
				send_word(OP_READ_REG, rand_addr, rand_data);
		end
	endtask

	task automatic test_halt();
		word_t ins;
		write_program_length(13'd4096);
		ins = $urandom();
		ins[OPC_LSB +: 3] = OPC_HALT;
		send_word(OP_WRITE_MEM, pc_image, ins);
		send_word(OP_EXECUTE, 12'h0, 32'h0);
		send_word(OP_EXECUTE, 12'h0, 32'h0);
		send_word(OP_WRITE_MEM, 12'hABC, 32'h1234_5678);
		send_word(OP_READ_MEM, 12'hABC, 32'h0);
		send_word(OP_READ_REG, 12'd5, 32'h0);
	endtask

	always @(posedge clk) begin : check_results
		exec_result_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing pending");
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, read_data);
					failures++;
				end
				if (program_counter !== want.pc) begin
					$error("program_counter: expected %0d, got %0d", want.pc, program_counter);
					failures++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					failures++;
				end
				if (executed_count !== want.count) begin
					$error("executed_count: expected %0d, got %0d", want.count,
						executed_count);
					failures++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb failed");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		start            = 1'b0;
		operation        = OP_WRITE_MEM;
		address          = '0;
		store_data       = '0;
		cfg_write_enable = 1'b0;
		cfg_data         = '0;
		failures         = 0;
		idle_on          = 1'b1;
		for (int i = 0; i < MEM_WORDS; i++)
			mem_image[i] = '0;
		for (int i = 0; i < NUM_REGS; i++)
			reg_image[i] = '0;
		pc_image     = '0;
		halted_image = 1'b0;
		count_image  = '0;
		length_image = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_directed_program();
		test_random_mix(400);
		write_program_length(13'($urandom_range(1, 4095)));
		test_random_mix(250);
		write_program_length(13'd0);
		test_random_mix(100);
		write_program_length(13'd64);
		test_random_mix(200);
		write_program_length(13'd4096);
		idle_on = 1'b0;
		test_random_mix(400);
		test_halt();

		while (pending_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (failures == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
